/* rtl/gcbd_pkg.sv */
// Package: types and constants shared by the gap-code bitmap decoder files.
package gcbd_pkg;

	// Escape code and the distance it skips
	localparam logic [4:0]  ESC_CODE = 5'h1F;
	localparam logic [31:0] ESC_SKIP = 32'(5'h1F) << 1;

	// Configuration register indexes
	localparam logic [7:0] CFG_MAP_BYTES    = 8'd0;
	localparam logic [7:0] CFG_START_OFFSET = 8'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic [31:0] bit_position;
		logic        has_position;
		logic        stream_done;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] map_bytes;
		logic        start_offset;
	} cfg_t;

	// Results of one decoded byte: 0 to 2 result items
	typedef struct packed {
		logic [1:0] count;
		out_item_t  r0;
		out_item_t  r1;
	} dec_res_t;

endpackage

/* rtl/gcbd_decode.sv */
// Decoder: code extraction from one byte and the decode state registers.
module gcbd_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  gcbd_pkg::cfg_t     cfg,
	input  gcbd_pkg::in_item_t item,
	input  logic               advance,
	output gcbd_pkg::dec_res_t res
);

	typedef struct packed {
		logic [31:0] pos;
		logic [39:0] cons;
		logic        fin;
		logic [31:0] res_pos;
		logic        has;
	} step_t;

	logic [31:0] position_q;
	logic [39:0] consumed_q;
	logic        finished_q;
	logic [3:0]  pend_bits_q;
	logic [2:0]  pend_cnt_q;

	logic [31:0] pos0;
	logic [39:0] cons0;
	logic        fin0;
	logic [3:0]  pb0;
	logic [2:0]  pc0;
	logic        ended0, ended1, ended2, two;
	logic [11:0] bits;
	logic [3:0]  cnt;
	step_t       st1, st2;

	logic [31:0] pos_d;
	logic [39:0] cons_d;
	logic        fin_d;
	logic [3:0]  pb_d;
	logic [2:0]  pc_d;

	// Stream has ended: a fresh stream ends only on an empty map
	function automatic logic is_ended(input logic [39:0] cons, input logic fin,
		input logic [31:0] map);
		return (cons == 40'd0) ? (map == 32'd0) : fin;
	endfunction

	// One code step: position advance, consumed count, end check
	function automatic step_t code_step(input logic [31:0] pos, input logic [39:0] cons,
		input logic fin, input logic [4:0] code, input gcbd_pkg::cfg_t c);
		step_t       s;
		logic [31:0] p;
		logic [31:0] stp;
		p = (cons == 40'd0) ? {31'd0, c.start_offset} : pos;
		s.fin = fin;
		if (code == gcbd_pkg::ESC_CODE) begin
			p = p + gcbd_pkg::ESC_SKIP;
			s.cons = cons + {8'd0, gcbd_pkg::ESC_SKIP};
			if (s.cons[39:3] > {5'd0, c.map_bytes})
				s.fin = 1'b1;
			s.res_pos = 32'd0;
			s.has = 1'b0;
		end else begin
			stp = {26'd0, code, 1'b0};
			p = p + stp + 32'd1;
			s.res_pos = p;
			s.has = 1'b1;
			p = p + 32'd1;
			s.cons = cons + {8'd0, stp} + 40'd2;
			if (s.cons[39:3] >= {5'd0, c.map_bytes})
				s.fin = 1'b1;
		end
		s.pos = p;
		return s;
	endfunction

	// Decode up to two codes from the pending bits and this byte
	always_comb begin
		pos0  = item.restart ? {31'd0, cfg.start_offset} : position_q;
		cons0 = item.restart ? 40'd0 : consumed_q;
		fin0  = item.restart ? (cfg.map_bytes == 32'd0) : finished_q;
		pb0   = item.restart ? 4'd0 : pend_bits_q;
		pc0   = item.restart ? 3'd0 : pend_cnt_q;

		ended0 = is_ended(cons0, fin0, cfg.map_bytes);
		bits   = {8'd0, pb0} | ({4'd0, item.data_byte} << pc0);
		cnt    = {1'b0, pc0} + 4'd8;

		st1    = code_step(pos0, cons0, fin0, bits[4:0], cfg);
		ended1 = is_ended(st1.cons, st1.fin, cfg.map_bytes);
		two    = (cnt >= 4'd10) && !ended1;
		st2    = code_step(st1.pos, st1.cons, st1.fin, bits[9:5], cfg);
		ended2 = is_ended(st2.cons, st2.fin, cfg.map_bytes);

		res.r0 = '{bit_position: st1.res_pos, has_position: st1.has,
			stream_done: st1.fin, last: !two};
		res.r1 = '{bit_position: st2.res_pos, has_position: st2.has,
			stream_done: st2.fin, last: 1'b1};

		if (ended0) begin
			res.count = 2'd0;
			pos_d  = pos0;
			cons_d = cons0;
			fin_d  = fin0;
			pb_d   = 4'd0;
			pc_d   = 3'd0;
		end else if (two) begin
			res.count = 2'd2;
			pos_d  = st2.pos;
			cons_d = st2.cons;
			fin_d  = st2.fin;
			pb_d   = ended2 ? 4'd0 : {2'd0, bits[11:10]};
			pc_d   = ended2 ? 3'd0 : 3'(cnt - 4'd10);
		end else begin
			res.count = 2'd1;
			pos_d  = st1.pos;
			cons_d = st1.cons;
			fin_d  = st1.fin;
			pb_d   = ended1 ? 4'd0 : bits[8:5];
			pc_d   = ended1 ? 3'd0 : 3'(cnt - 4'd5);
		end
	end

	// Decode state, updated when the byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= 32'd0;
			consumed_q  <= 40'd0;
			finished_q  <= 1'b1;
			pend_bits_q <= 4'd0;
			pend_cnt_q  <= 3'd0;
		end else if (advance) begin
			position_q  <= pos_d;
			consumed_q  <= cons_d;
			finished_q  <= fin_d;
			pend_bits_q <= pb_d;
			pend_cnt_q  <= pc_d;
		end
	end

endmodule

/* rtl/gcbd_out_buf.sv */
// Result buffer: holds the results of one byte and hands them out one at a time.
module gcbd_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  gcbd_pkg::dec_res_t  res,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output gcbd_pkg::out_item_t out_data
);

	logic [1:0]          cnt_q;
	gcbd_pkg::out_item_t slot0_q, slot1_q;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot0_q;
	// Room for a new pair once the buffer drains this cycle
	assign space     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Slots: the second shifts forward after the first is taken
	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= res.r0;
			slot1_q <= res.r1;
		end else if (out_valid && out_ready) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

/* rtl/gap_code_bitmap_decoder.sv */
// Top level: gap-code bitmap decoder with input register, decoder and result buffer.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------
//  in      | in  | in_valid / in_ready   | in_data  (data_byte, restart)
//  out     | out | out_valid / out_ready | out_data (bit_position, has_position,
//          |     |                       |           stream_done, last)
//  cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A byte waits in the input register, is decoded there combinationally
// and writes its 0 to 2 results into the result buffer once the buffer has room.
// The single result port hands out results one at a time: a byte giving two codes
// holds the output for both results, and a new byte is taken once the buffer has room.
// Reset clears the decode state, the input register and the result buffer.
// A stalled output backs up into the input register and then into in_ready.
module gap_code_bitmap_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gcbd_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output gcbd_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	gcbd_pkg::cfg_t     cfg_q;
	gcbd_pkg::in_item_t item_s1;
	logic               valid_s1;
	logic               space;
	logic               advance;
	gcbd_pkg::dec_res_t res;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && space;
	assign in_ready  = !valid_s1 || space;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				gcbd_pkg::CFG_MAP_BYTES:    cfg_q.map_bytes    <= cfg_data;
				gcbd_pkg::CFG_START_OFFSET: cfg_q.start_offset <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
	end

	gcbd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item    (item_s1),
		.advance (advance),
		.res     (res)
	);

	gcbd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// An accepted byte lands in the input register
	a_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted byte missing from input register");

	// A two-code byte shows its first result, not marked last
	a_pair_first: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (res.count == 2'd2) |=> out_valid && !out_data.last)
		else $error("first result of a pair missing or marked last");

	// The second result of a pair follows its first
	a_pair_second: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> out_valid && out_data.last)
		else $error("second result of a pair missing");

endmodule

/* verif/tb_gap_code_bitmap_decoder.sv */
// Testbench for the gap-code bitmap decoder: directed table, random streams, scoreboard.
module tb_gap_code_bitmap_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BYTES  = 80;

	// Directed table row: either a register setting or one byte
	typedef enum logic {ROW_REGS, ROW_BYTE} row_kind_t;

	typedef struct packed {
		logic                typed;
		logic [1:0]          n;
		gcbd_pkg::out_item_t r0;
		gcbd_pkg::out_item_t r1;
	} byte_note_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] map;
		logic        start;
		logic [7:0]  data_byte;
		logic        restart;
		byte_note_t  note;
	} step_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	gcbd_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	gcbd_pkg::out_item_t out_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [7:0]          cfg_index = '0;
	logic [31:0]         cfg_data = '0;

	gap_code_bitmap_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Decoder mirror: configuration and stream state
	logic [31:0] cfg_map = '0;
	logic        cfg_start = 1'b0;
	logic [31:0] cur_pos = '0;
	logic [39:0] used_bits = '0;
	logic [39:0] pend_bits = '0;
	logic [5:0]  pend_cnt = '0;
	logic        map_done = 1'b1;

	gcbd_pkg::out_item_t bit_events_q [$];
	byte_note_t          byte_notes_q [$];
	step_row_t           dir_rows [$];

	int          mismatches = 0;
	int          cycle_count = 0;
	int          live_bytes = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	bit          press_mode = 1'b0;

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic void clear_stream();
		cur_pos = {31'b0, cfg_start};
		used_bits = '0;
		pend_bits = '0;
		pend_cnt = '0;
		map_done = (cfg_map == '0);
	endfunction

	// Before the first code the live registers decide whether the map is empty
	function automatic bit stream_over();
		if (used_bits == '0)
			return cfg_map == '0;
		return map_done;
	endfunction

	// Unpack one byte into 0 to 2 codes and return the results they give
	function automatic int decode_byte(input gcbd_pkg::in_item_t it,
			output gcbd_pkg::out_item_t r0, output gcbd_pkg::out_item_t r1);
		int                  n;
		logic [4:0]          code;
		logic [31:0]         step;
		gcbd_pkg::out_item_t r;
		n = 0;
		r0 = '0;
		r1 = '0;
		if (it.restart)
			clear_stream();
		if (stream_over()) begin
			pend_bits = '0;
			pend_cnt = '0;
			return 0;
		end
		pend_bits = pend_bits | (40'(it.data_byte) << pend_cnt[4:0]);
		pend_cnt = pend_cnt + 6'd8;
		while (pend_cnt >= 6'd5 && !stream_over()) begin
			code = pend_bits[4:0];
			pend_bits = pend_bits >> 5;
			pend_cnt = pend_cnt - 6'd5;
			if (used_bits == '0)
				cur_pos = {31'b0, cfg_start};
			r = '0;
			if (code == gcbd_pkg::ESC_CODE) begin
				cur_pos = cur_pos + gcbd_pkg::ESC_SKIP;
				used_bits = used_bits + 40'(gcbd_pkg::ESC_SKIP);
				if ((used_bits >> 3) > 40'(cfg_map))
					map_done = 1'b1;
			end else begin
				step = {26'b0, code, 1'b0};
				cur_pos = cur_pos + step + 32'd1;
				r.bit_position = cur_pos;
				r.has_position = 1'b1;
				cur_pos = cur_pos + 32'd1;
				used_bits = used_bits + 40'(step) + 40'd2;
				if ((used_bits >> 3) >= 40'(cfg_map))
					map_done = 1'b1;
			end
			r.stream_done = map_done;
			if (n == 0)
				r0 = r;
			else
				r1 = r;
			n++;
		end
		if (stream_over()) begin
			pend_bits = '0;
			pend_cnt = '0;
		end
		if (n == 1)
			r0.last = 1'b1;
		else if (n == 2)
			r1.last = 1'b1;
		return n;
	endfunction

	// Scoreboard: compare results, then track config and accepted bytes
	always @(posedge clk) begin
		gcbd_pkg::out_item_t want;
		gcbd_pkg::out_item_t p0;
		gcbd_pkg::out_item_t p1;
		byte_note_t          note;
		int                  n;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (bit_events_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result pos %0d", out_data.bit_position));
				end else begin
					want = bit_events_q.pop_front();
					if (out_data.bit_position !== want.bit_position)
						report_mismatch($sformatf("bit_position %0d, want %0d",
							out_data.bit_position, want.bit_position));
					if (out_data.has_position !== want.has_position)
						report_mismatch($sformatf("has_position %b, want %b",
							out_data.has_position, want.has_position));
					if (out_data.stream_done !== want.stream_done)
						report_mismatch($sformatf("stream_done %b, want %b",
							out_data.stream_done, want.stream_done));
					if (out_data.last !== want.last)
						report_mismatch($sformatf("last %b, want %b",
							out_data.last, want.last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == gcbd_pkg::CFG_MAP_BYTES)
					cfg_map = cfg_data;
				else if (cfg_index == gcbd_pkg::CFG_START_OFFSET)
					cfg_start = cfg_data[0];
			end
			if (in_valid && in_ready) begin
				note = (byte_notes_q.size() != 0) ? byte_notes_q.pop_front() : '0;
				n = decode_byte(in_data, p0, p1);
				if (n > 0)
					live_bytes++;
				if (note.typed) begin
					n = note.n;
					p0 = note.r0;
					p1 = note.r1;
				end
				if (n > 0)
					bit_events_q.push_back(p0);
				if (n > 1)
					bit_events_q.push_back(p1);
			end
		end
	end

	// Receiver: random stalls, plus long hold-offs in the pressure phase
	always @(posedge clk or negedge arst_n) begin
		int hold_left;
		bit held_once;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
			held_once = 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (press_mode && (!held_once || $urandom_range(0, 49) == 0)) begin
			hold_left = $urandom_range(80, 150);
			held_once = 1'b1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic gcbd_pkg::out_item_t res(input logic [31:0] pos, input logic has,
			input logic done, input logic lst);
		gcbd_pkg::out_item_t r;
		r.bit_position = pos;
		r.has_position = has;
		r.stream_done = done;
		r.last = lst;
		return r;
	endfunction

	function automatic step_row_t regs_row(input logic [31:0] map, input logic start);
		step_row_t row;
		row = '0;
		row.kind = ROW_REGS;
		row.map = map;
		row.start = start;
		return row;
	endfunction

	function automatic step_row_t byte_row(input logic [7:0] b, input logic rs);
		step_row_t row;
		row = '0;
		row.kind = ROW_BYTE;
		row.data_byte = b;
		row.restart = rs;
		return row;
	endfunction

	function automatic step_row_t typed_row(input logic [7:0] b, input logic rs,
			input logic [1:0] n, input gcbd_pkg::out_item_t r0,
			input gcbd_pkg::out_item_t r1);
		step_row_t row;
		row = byte_row(b, rs);
		row.note.typed = 1'b1;
		row.note.n = n;
		row.note.r0 = r0;
		row.note.r1 = r1;
		return row;
	endfunction

	// Offer one byte; sender idles afterwards at the current rate
	task automatic offer_byte(input logic [7:0] b, input logic rs, input byte_note_t note);
		byte_notes_q.push_back(note);
		in_data <= '{data_byte: b, restart: rs};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Write both registers back to back
	task automatic load_regs(input logic [31:0] map, input logic start);
		cfg_index <= gcbd_pkg::CFG_MAP_BYTES;
		cfg_data <= map;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= gcbd_pkg::CFG_START_OFFSET;
		cfg_data <= {31'b0, start};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Wait for every expected result, then for a byte that gives none to clear
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (byte_notes_q.size() != 0 || bit_events_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	int unsigned ph_map   [5] = '{32'hFFFF_FFFF, 1, 37, 200, 3000};
	bit          ph_start [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
	int          ph_len   [5] = '{30, 3, 10, 40, 40};
	int          ph_idle  [5] = '{0, 65, 0, 28, 0};
	int          ph_stall [5] = '{0, 0, 65, 28, 0};

	initial begin
		step_row_t  row;
		logic [7:0] b;
		logic       rs;
		int         len;
		int         base;

		// Directed table: empty map, fresh stream, escapes, stream end, extremes
		dir_rows.push_back(typed_row(8'hA5, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(typed_row(8'hFF, 1'b1, 2'd0, '0, '0));
		dir_rows.push_back(regs_row(32'd100, 1'b1));
		// End flag left set by the empty map carries into this fresh stream
		dir_rows.push_back(typed_row(8'h00, 1'b0, 2'd1, res(32'd2, 1'b1, 1'b1, 1'b1), '0));
		dir_rows.push_back(byte_row(8'h00, 1'b0));
		dir_rows.push_back(byte_row(8'hFF, 1'b0));
		dir_rows.push_back(regs_row(32'hFFFF_FFFF, 1'b0));
		dir_rows.push_back(typed_row(8'hFF, 1'b1, 2'd1, res(32'd0, 1'b0, 1'b0, 1'b1), '0));
		dir_rows.push_back(typed_row(8'hFF, 1'b0, 2'd2, res(32'd0, 1'b0, 1'b0, 1'b0),
			res(32'd0, 1'b0, 1'b0, 1'b1)));
		dir_rows.push_back(typed_row(8'h00, 1'b1, 2'd1, res(32'd1, 1'b1, 1'b0, 1'b1), '0));
		dir_rows.push_back(byte_row(8'h5A, 1'b0));
		dir_rows.push_back(byte_row(8'h3C, 1'b0));
		dir_rows.push_back(byte_row(8'h81, 1'b0));
		dir_rows.push_back(regs_row(32'd1, 1'b1));
		dir_rows.push_back(typed_row(8'h03, 1'b1, 2'd1, res(32'd8, 1'b1, 1'b1, 1'b1), '0));
		dir_rows.push_back(typed_row(8'h55, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(typed_row(8'h00, 1'b1, 2'd1, res(32'd2, 1'b1, 1'b0, 1'b1), '0));
		dir_rows.push_back(byte_row(8'hE0, 1'b0));
		dir_rows.push_back(regs_row(32'd6, 1'b0));
		dir_rows.push_back(typed_row(8'hFF, 1'b1, 2'd1, res(32'd0, 1'b0, 1'b1, 1'b1), '0));
		dir_rows.push_back(typed_row(8'h00, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(regs_row(32'd7, 1'b0));
		dir_rows.push_back(typed_row(8'hFF, 1'b1, 2'd1, res(32'd0, 1'b0, 1'b0, 1'b1), '0));
		dir_rows.push_back(typed_row(8'hFF, 1'b0, 2'd1, res(32'd0, 1'b0, 1'b1, 1'b1), '0));
		dir_rows.push_back(regs_row(32'd0, 1'b1));
		dir_rows.push_back(typed_row(8'h12, 1'b1, 2'd0, '0, '0));
		dir_rows.push_back(typed_row(8'h12, 1'b0, 2'd0, '0, '0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_REGS) begin
				settle();
				load_regs(row.map, row.start);
			end else begin
				offer_byte(row.data_byte, row.restart, row.note);
			end
		end

		// Random streams across configuration and idling phases
		for (int ph = 0; ph < 5; ph++) begin
			settle();
			load_regs(ph_map[ph], ph_start[ph]);
			idle_pct = ph_idle[ph];
			stall_pct = ph_stall[ph];
			press_mode = (ph == 4);
			base = live_bytes;
			while (live_bytes - base < PHASE_BYTES) begin
				len = $urandom_range(1, ph_len[ph]);
				for (int k = 0; k < len; k++) begin
					case ($urandom_range(0, 19))
						0, 1: begin
							b = 8'hFF;
						end
						2: begin
							b = 8'h00;
						end
						default: begin
							b = 8'($urandom_range(0, 255));
						end
					endcase
					if (k == 0)
						rs = ($urandom_range(0, 9) != 0);
					else
						rs = ($urandom_range(0, 19) == 0);
					offer_byte(b, rs, '0);
				end
			end
		end

		press_mode = 1'b0;
		stall_pct = 0;
		settle();

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* gap_code_bitmap_decoder.f */
rtl/gcbd_pkg.sv
rtl/gcbd_decode.sv
rtl/gcbd_out_buf.sv
rtl/gap_code_bitmap_decoder.sv
verif/tb_gap_code_bitmap_decoder.sv
